@@ rtl/rmsb_pkg.sv @@
// Shared constants and types for the block-decomposed range minimum unit.
// No dependencies; imported by rmsb_min_acc and range_minimum_sqrt_blocks.
package rmsb_pkg;

    localparam int C_DEPTH = 4096;
    localparam int C_BLOCK = 64;
    localparam int C_IDX_W = $clog2(C_DEPTH);
    localparam int C_OFF_W = $clog2(C_BLOCK);
    localparam int C_BLK_W = C_IDX_W - C_OFF_W;
    localparam int C_NBLK = C_DEPTH / C_BLOCK;
    localparam int C_PTR_W = C_IDX_W + 1;
    localparam int C_VAL_W = 30;

    localparam logic [C_VAL_W-1:0] C_SENTINEL = 30'd1000000000;

    typedef logic [C_VAL_W-1:0] t_val;

    // Operation carried in the func field of an input transfer.
    typedef enum logic {
        OP_UPDATE = 1'b0,
        OP_QUERY  = 1'b1
    } t_op;

    // Control from the sequencer to the running-minimum unit.
    typedef struct packed {
        logic start;    // load the sentinel, a new scan begins
        logic pend_el;  // element read data arrives this cycle
        logic pend_bk;  // block minimum read data arrives this cycle
    } t_acc_ctl;

endpackage

@@ rtl/rmsb_min_acc.sv @@
// Running minimum over the read data returned by the two memories.
// Depends on rmsb_pkg.
module rmsb_min_acc (
    input  logic              i_clk,
    input  rmsb_pkg::t_acc_ctl i_ctl,
    input  rmsb_pkg::t_val    i_el_data,
    input  rmsb_pkg::t_val    i_bk_data,
    output rmsb_pkg::t_val    o_acc,
    output rmsb_pkg::t_val    o_acc_next
);
    import rmsb_pkg::*;

    t_val r_acc;
    t_val n_acc;
    t_val w_data;

    always_comb begin
        w_data = i_ctl.pend_bk ? i_bk_data : i_el_data;
        n_acc = r_acc;
        if (i_ctl.start) begin
            n_acc = C_SENTINEL;
        end else if ((i_ctl.pend_el || i_ctl.pend_bk) && (w_data < r_acc)) begin
            n_acc = w_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
    end

    assign o_acc = r_acc;
    assign o_acc_next = n_acc;

endmodule

@@ rtl/range_minimum_sqrt_blocks.sv @@
// Range minimum unit: element store plus one stored minimum per block of 64.
// Update: one element write, then 64 element reads, then one block write.
// Query: one memory read per cycle, each leading or trailing element or whole block,
// at most 63+63+62 reads; an empty range reads nothing. One item at a time.
// After reset a clearing pass over all 4096 element addresses fills both memories with 1000000000;
// no item is taken during it. Depends on rmsb_pkg and rmsb_min_acc.
module range_minimum_sqrt_blocks (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic                         i_func,
    input  logic [rmsb_pkg::C_IDX_W-1:0] i_position,
    input  logic [rmsb_pkg::C_VAL_W-1:0] i_new_value,
    input  logic [rmsb_pkg::C_IDX_W-1:0] i_left_index,
    input  logic [rmsb_pkg::C_IDX_W-1:0] i_right_index,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [rmsb_pkg::C_VAL_W-1:0] o_range_min
);
    import rmsb_pkg::*;

    localparam logic [2:0] S_CLEAR    = 3'd0;
    localparam logic [2:0] S_IDLE     = 3'd1;
    localparam logic [2:0] S_UPD_WR   = 3'd2;
    localparam logic [2:0] S_UPD_SCAN = 3'd3;
    localparam logic [2:0] S_UPD_WB   = 3'd4;
    localparam logic [2:0] S_QRY      = 3'd5;
    localparam logic [2:0] S_DONE     = 3'd6;

    logic [2:0]         r_state, n_state;
    logic [C_PTR_W-1:0] r_cur, n_cur;
    logic [C_IDX_W-1:0] r_hi, n_hi;
    t_val               r_val, n_val;
    logic               r_pend_el, r_pend_bk;
    logic               r_out_valid, n_out_valid;
    t_val               r_range_min, n_range_min;

    t_val r_el_mem [C_DEPTH];
    t_val r_bk_mem [C_NBLK];
    t_val r_el_rd;
    t_val r_bk_rd;

    logic               el_we, el_re, bk_we, bk_re;
    t_val               el_wd, bk_wd;
    logic [C_BLK_W-1:0] bk_addr;
    logic [C_PTR_W-1:0] w_cur_end;
    logic               w_whole, w_done, w_accept;
    t_val               w_sat;
    t_acc_ctl           acc_ctl;
    t_val               acc, acc_next;

    assign o_ready = (r_state == S_IDLE);
    assign w_accept = i_valid && o_ready;
    assign w_sat = (i_new_value > C_SENTINEL) ? C_SENTINEL : i_new_value;

    // A whole block is taken when the pointer is aligned and the block ends inside the range.
    assign w_cur_end = r_cur + C_PTR_W'(C_BLOCK - 1);
    assign w_whole = (r_cur[C_OFF_W-1:0] == '0) && (w_cur_end <= {1'b0, r_hi});
    assign w_done = (r_cur > {1'b0, r_hi});

    always_comb begin
        n_state = r_state;
        n_cur = r_cur;
        n_hi = r_hi;
        n_val = r_val;
        n_out_valid = r_out_valid && !i_ready;
        n_range_min = r_range_min;
        el_we = 1'b0;
        el_re = 1'b0;
        el_wd = r_val;
        bk_we = 1'b0;
        bk_re = 1'b0;
        bk_wd = acc_next;
        bk_addr = r_cur[C_IDX_W-1:C_OFF_W];
        acc_ctl = '0;

        unique case (r_state)
            S_CLEAR: begin
                el_we = 1'b1;
                el_wd = C_SENTINEL;
                bk_we = 1'b1;
                bk_wd = C_SENTINEL;
                bk_addr = r_cur[C_BLK_W-1:0];
                n_cur = r_cur + C_PTR_W'(1);
                if (r_cur[C_IDX_W-1:0] == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    acc_ctl.start = 1'b1;
                    if (i_func == OP_UPDATE) begin
                        n_cur = {1'b0, i_position};
                        n_val = w_sat;
                        n_state = S_UPD_WR;
                    end else begin
                        n_cur = {1'b0, i_left_index};
                        n_hi = i_right_index;
                        n_state = (i_left_index > i_right_index) ? S_DONE : S_QRY;
                    end
                end
            end
            S_UPD_WR: begin
                el_we = 1'b1;
                n_cur = {1'b0, r_cur[C_IDX_W-1:C_OFF_W], {C_OFF_W{1'b0}}};
                n_state = S_UPD_SCAN;
            end
            S_UPD_SCAN: begin
                el_re = 1'b1;
                n_cur = r_cur + C_PTR_W'(1);
                if (r_cur[C_OFF_W-1:0] == '1) begin
                    n_state = S_UPD_WB;
                end
            end
            S_UPD_WB: begin
                // The last element arrives now; write the merged minimum straight back.
                bk_we = 1'b1;
                bk_addr = r_cur[C_IDX_W-1:C_OFF_W] - C_BLK_W'(1);
                n_state = S_IDLE;
            end
            S_QRY: begin
                if (w_done) begin
                    n_state = S_DONE;
                end else if (w_whole) begin
                    bk_re = 1'b1;
                    n_cur = r_cur + C_PTR_W'(C_BLOCK);
                end else begin
                    el_re = 1'b1;
                    n_cur = r_cur + C_PTR_W'(1);
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_ready) begin
                    n_out_valid = 1'b1;
                    n_range_min = acc;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        acc_ctl.pend_el = r_pend_el;
        acc_ctl.pend_bk = r_pend_bk;
    end

    rmsb_min_acc u_min_acc (
        .i_clk      (i_clk),
        .i_ctl      (acc_ctl),
        .i_el_data  (r_el_rd),
        .i_bk_data  (r_bk_rd),
        .o_acc      (acc),
        .o_acc_next (acc_next)
    );

    always_ff @(posedge i_clk) begin
        if (el_we) begin
            r_el_mem[r_cur[C_IDX_W-1:0]] <= el_wd;
        end
        if (el_re) begin
            r_el_rd <= r_el_mem[r_cur[C_IDX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (bk_we) begin
            r_bk_mem[bk_addr] <= bk_wd;
        end
        if (bk_re) begin
            r_bk_rd <= r_bk_mem[bk_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_cur <= '0;
            r_pend_el <= 1'b0;
            r_pend_bk <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cur <= n_cur;
            r_pend_el <= el_re;
            r_pend_bk <= bk_re;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hi <= n_hi;
        r_val <= n_val;
        r_range_min <= n_range_min;
    end

    assign o_valid = r_out_valid;
    assign o_range_min = r_range_min;

endmodule
